[src/lorenz_midpoint_step_assert.svh]
// Assertion macros for the Lorenz midpoint step block.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef LORENZ_MIDPOINT_STEP_ASSERT_SVH
`define LORENZ_MIDPOINT_STEP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lorenz_midpoint_step: port property violated");

// Next-cycle implication, sampled on clk, off during reset
`define LMS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lorenz_midpoint_step: port property violated");

`endif

[src/lms_pkg.sv]
// Shared types and constants of the Lorenz midpoint step block.
// No dependencies; used by the interfaces, the derivative pipeline and the top level.
package lms_pkg;

    // Configuration register sizes
    localparam int CFG_REG_W   = 31;
    localparam int STEP_W      = 16;
    localparam int STEP_FRAC   = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // Reset values: sigma 10, rho 28, beta 8/3 (Q15.16), dt 0.015 (Q0.16)
    localparam logic [CFG_REG_W-1:0] SIGMA_RESET     = CFG_REG_W'(655360);
    localparam logic [CFG_REG_W-1:0] RHO_RESET       = CFG_REG_W'(1835008);
    localparam logic [CFG_REG_W-1:0] BETA_RESET      = CFG_REG_W'(174763);
    localparam logic [STEP_W-1:0]    TIME_STEP_RESET = STEP_W'(983);

    // Register indexes on the configuration channel
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIGMA     = CFG_INDEX_W'(0),
        CFG_RHO       = CFG_INDEX_W'(1),
        CFG_BETA      = CFG_INDEX_W'(2),
        CFG_TIME_STEP = CFG_INDEX_W'(3)
    } cfg_index_t;

    // Per-stage status that travels with each item
    typedef struct packed {
        logic valid;
        logic ovf;
    } stage_flags_t;

endpackage

[src/lms_ifs.sv]
// Channel interfaces of the Lorenz midpoint step block: position in, result out, config.
// Depends on lms_pkg for the configuration field widths.
interface lms_pos_if #(parameter int WORD_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] pos_x;
    logic signed [WORD_WIDTH-1:0] pos_y;
    logic signed [WORD_WIDTH-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface lms_next_if #(parameter int WORD_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] next_x;
    logic signed [WORD_WIDTH-1:0] next_y;
    logic signed [WORD_WIDTH-1:0] next_z;
    logic                         overflow;

    modport source (output valid, output next_x, output next_y, output next_z,
                    output overflow, input ready);
    modport sink   (input valid, input next_x, input next_y, input next_z,
                    input overflow, output ready);
endinterface

interface lms_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lms_pkg::CFG_INDEX_W-1:0]  index;
    logic [lms_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/lms_deriv_step.sv]
// Seven-stage pipeline: Lorenz derivative at a point, scaled by a step, added to a base.
// Depends on lms_pkg; instantiated twice by lorenz_midpoint_step.
module lms_deriv_step #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  lms_pkg::stage_flags_t               in_flags,
    input  logic signed [WORD_WIDTH-1:0]        x,
    input  logic signed [WORD_WIDTH-1:0]        y,
    input  logic signed [WORD_WIDTH-1:0]        z,
    input  logic signed [WORD_WIDTH-1:0]        base_x,
    input  logic signed [WORD_WIDTH-1:0]        base_y,
    input  logic signed [WORD_WIDTH-1:0]        base_z,
    input  logic [lms_pkg::CFG_REG_W-1:0]       sigma,
    input  logic [lms_pkg::CFG_REG_W-1:0]       rho,
    input  logic [lms_pkg::CFG_REG_W-1:0]       beta,
    input  logic [lms_pkg::STEP_W-1:0]          step,
    output lms_pkg::stage_flags_t               out_flags,
    output logic signed [WORD_WIDTH-1:0]        next_x,
    output logic signed [WORD_WIDTH-1:0]        next_y,
    output logic signed [WORD_WIDTH-1:0]        next_z,
    output logic signed [WORD_WIDTH-1:0]        base_x_out,
    output logic signed [WORD_WIDTH-1:0]        base_y_out,
    output logic signed [WORD_WIDTH-1:0]        base_z_out
);

    localparam int W   = WORD_WIDTH;
    // Operand width of the register side of a product, and the exact product width
    localparam int OPW = (W > 32) ? W : 32;
    localparam int PW  = W + OPW;

    localparam logic signed [PW-1:0] WMAX_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [PW-1:0] WMIN_P = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

    // Clamp to the word range; top bit of the result is the saturation flag
    function automatic logic [W:0] sat_w(input logic signed [PW-1:0] v);
        logic [W:0] r;
        if (v > WMAX_P)
            r = {1'b1, WMAX_P[W-1:0]};
        else if (v < WMIN_P)
            r = {1'b1, WMIN_P[W-1:0]};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // Registers widened to signed product operands
    logic signed [PW-1:0] sigma_x, rho_x, beta_x, step_x;
    assign sigma_x = signed'(PW'(sigma));
    assign rho_x   = signed'(PW'(rho));
    assign beta_x  = signed'(PW'(beta));
    assign step_x  = signed'(PW'(step));

    // Stage 1: y - x and rho - z
    logic [W:0] dyx_s, drz_s;
    assign dyx_s = sat_w(PW'(y) - PW'(x));
    assign drz_s = sat_w(rho_x - PW'(z));

    lms_pkg::stage_flags_t flags_s1_reg;
    logic signed [W-1:0]   x_s1_reg, y_s1_reg, z_s1_reg;
    logic signed [W-1:0]   bx_s1_reg, by_s1_reg, bz_s1_reg;
    logic signed [W-1:0]   dyx_s1_reg, drz_s1_reg;

    // Stage 2: the four exact products
    lms_pkg::stage_flags_t flags_s2_reg;
    logic signed [W-1:0]   y_s2_reg;
    logic signed [W-1:0]   bx_s2_reg, by_s2_reg, bz_s2_reg;
    logic signed [PW-1:0]  p_sd_s2_reg, p_xr_s2_reg, p_xy_s2_reg, p_bz_s2_reg;

    // Stage 3: floor shift and clamp of the products
    logic [W:0] m_sd_s, m_xr_s, m_xy_s, m_bz_s;
    assign m_sd_s = sat_w(p_sd_s2_reg >>> FRAC_BITS);
    assign m_xr_s = sat_w(p_xr_s2_reg >>> FRAC_BITS);
    assign m_xy_s = sat_w(p_xy_s2_reg >>> FRAC_BITS);
    assign m_bz_s = sat_w(p_bz_s2_reg >>> FRAC_BITS);

    lms_pkg::stage_flags_t flags_s3_reg;
    logic signed [W-1:0]   y_s3_reg;
    logic signed [W-1:0]   bx_s3_reg, by_s3_reg, bz_s3_reg;
    logic signed [W-1:0]   dx_s3_reg, m_xr_s3_reg, m_xy_s3_reg, m_bz_s3_reg;

    // Stage 4: dy = x(rho - z) - y, dz = xy - beta z
    logic [W:0] dy_s, dz_s;
    assign dy_s = sat_w(PW'(m_xr_s3_reg) - PW'(y_s3_reg));
    assign dz_s = sat_w(PW'(m_xy_s3_reg) - PW'(m_bz_s3_reg));

    lms_pkg::stage_flags_t flags_s4_reg;
    logic signed [W-1:0]   bx_s4_reg, by_s4_reg, bz_s4_reg;
    logic signed [W-1:0]   dx_s4_reg, dy_s4_reg, dz_s4_reg;

    // Stage 5: derivative times step
    lms_pkg::stage_flags_t flags_s5_reg;
    logic signed [W-1:0]   bx_s5_reg, by_s5_reg, bz_s5_reg;
    logic signed [PW-1:0]  q_x_s5_reg, q_y_s5_reg, q_z_s5_reg;

    // Stage 6: floor shift and clamp of the increments
    logic [W:0] h_x_s, h_y_s, h_z_s;
    assign h_x_s = sat_w(q_x_s5_reg >>> lms_pkg::STEP_FRAC);
    assign h_y_s = sat_w(q_y_s5_reg >>> lms_pkg::STEP_FRAC);
    assign h_z_s = sat_w(q_z_s5_reg >>> lms_pkg::STEP_FRAC);

    lms_pkg::stage_flags_t flags_s6_reg;
    logic signed [W-1:0]   bx_s6_reg, by_s6_reg, bz_s6_reg;
    logic signed [W-1:0]   h_x_s6_reg, h_y_s6_reg, h_z_s6_reg;

    // Stage 7: base plus increment
    logic [W:0] n_x_s, n_y_s, n_z_s;
    assign n_x_s = sat_w(PW'(bx_s6_reg) + PW'(h_x_s6_reg));
    assign n_y_s = sat_w(PW'(by_s6_reg) + PW'(h_y_s6_reg));
    assign n_z_s = sat_w(PW'(bz_s6_reg) + PW'(h_z_s6_reg));

    lms_pkg::stage_flags_t flags_s7_reg;
    logic signed [W-1:0]   bx_s7_reg, by_s7_reg, bz_s7_reg;
    logic signed [W-1:0]   n_x_s7_reg, n_y_s7_reg, n_z_s7_reg;

    // Valid and overflow flags, advancing with the pipeline enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_s1_reg <= '0;
            flags_s2_reg <= '0;
            flags_s3_reg <= '0;
            flags_s4_reg <= '0;
            flags_s5_reg <= '0;
            flags_s6_reg <= '0;
            flags_s7_reg <= '0;
        end
        else if (en)
        begin
            flags_s1_reg <= '{valid: in_flags.valid,
                              ovf: in_flags.ovf | dyx_s[W] | drz_s[W]};
            flags_s2_reg <= flags_s1_reg;
            flags_s3_reg <= '{valid: flags_s2_reg.valid,
                              ovf: flags_s2_reg.ovf | m_sd_s[W] | m_xr_s[W]
                                   | m_xy_s[W] | m_bz_s[W]};
            flags_s4_reg <= '{valid: flags_s3_reg.valid,
                              ovf: flags_s3_reg.ovf | dy_s[W] | dz_s[W]};
            flags_s5_reg <= flags_s4_reg;
            flags_s6_reg <= '{valid: flags_s5_reg.valid,
                              ovf: flags_s5_reg.ovf | h_x_s[W] | h_y_s[W] | h_z_s[W]};
            flags_s7_reg <= '{valid: flags_s6_reg.valid,
                              ovf: flags_s6_reg.ovf | n_x_s[W] | n_y_s[W] | n_z_s[W]};
        end
    end

    // Data path registers, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_s1_reg    <= x;
            y_s1_reg    <= y;
            z_s1_reg    <= z;
            bx_s1_reg   <= base_x;
            by_s1_reg   <= base_y;
            bz_s1_reg   <= base_z;
            dyx_s1_reg  <= dyx_s[W-1:0];
            drz_s1_reg  <= drz_s[W-1:0];

            y_s2_reg    <= y_s1_reg;
            bx_s2_reg   <= bx_s1_reg;
            by_s2_reg   <= by_s1_reg;
            bz_s2_reg   <= bz_s1_reg;
            p_sd_s2_reg <= sigma_x * PW'(dyx_s1_reg);
            p_xr_s2_reg <= PW'(x_s1_reg) * PW'(drz_s1_reg);
            p_xy_s2_reg <= PW'(x_s1_reg) * PW'(y_s1_reg);
            p_bz_s2_reg <= beta_x * PW'(z_s1_reg);

            y_s3_reg    <= y_s2_reg;
            bx_s3_reg   <= bx_s2_reg;
            by_s3_reg   <= by_s2_reg;
            bz_s3_reg   <= bz_s2_reg;
            dx_s3_reg   <= m_sd_s[W-1:0];
            m_xr_s3_reg <= m_xr_s[W-1:0];
            m_xy_s3_reg <= m_xy_s[W-1:0];
            m_bz_s3_reg <= m_bz_s[W-1:0];

            bx_s4_reg   <= bx_s3_reg;
            by_s4_reg   <= by_s3_reg;
            bz_s4_reg   <= bz_s3_reg;
            dx_s4_reg   <= dx_s3_reg;
            dy_s4_reg   <= dy_s[W-1:0];
            dz_s4_reg   <= dz_s[W-1:0];

            bx_s5_reg   <= bx_s4_reg;
            by_s5_reg   <= by_s4_reg;
            bz_s5_reg   <= bz_s4_reg;
            q_x_s5_reg  <= PW'(dx_s4_reg) * step_x;
            q_y_s5_reg  <= PW'(dy_s4_reg) * step_x;
            q_z_s5_reg  <= PW'(dz_s4_reg) * step_x;

            bx_s6_reg   <= bx_s5_reg;
            by_s6_reg   <= by_s5_reg;
            bz_s6_reg   <= bz_s5_reg;
            h_x_s6_reg  <= h_x_s[W-1:0];
            h_y_s6_reg  <= h_y_s[W-1:0];
            h_z_s6_reg  <= h_z_s[W-1:0];

            bx_s7_reg   <= bx_s6_reg;
            by_s7_reg   <= by_s6_reg;
            bz_s7_reg   <= bz_s6_reg;
            n_x_s7_reg  <= n_x_s[W-1:0];
            n_y_s7_reg  <= n_y_s[W-1:0];
            n_z_s7_reg  <= n_z_s[W-1:0];
        end
    end

    assign out_flags  = flags_s7_reg;
    assign next_x     = n_x_s7_reg;
    assign next_y     = n_y_s7_reg;
    assign next_z     = n_z_s7_reg;
    assign base_x_out = bx_s7_reg;
    assign base_y_out = by_s7_reg;
    assign base_z_out = bz_s7_reg;

endmodule

[src/lorenz_midpoint_step.sv]
// One midpoint (RK2) step of the Lorenz system per particle, signed fixed point, saturating.
// Takes one position item per clock unless halted, through two 7-stage derivative pipelines
// (half step, then full step from the start point) and an output register. Each pipeline
// stage holds on each path at most one multiplier of WORD_WIDTH by max(WORD_WIDTH, 32) bits
// or one add and clamp. The pipeline halts only while the output register holds an item not
// yet taken and the last stage is full; configuration writes are taken in any cycle.
// Depends on lms_pkg, lms_ifs and lms_deriv_step.
module lorenz_midpoint_step #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    lms_pos_if.sink    position,
    lms_next_if.source result,
    lms_cfg_if.sink    cfg
);

    localparam int W = WORD_WIDTH;

    // Configuration registers
    logic [lms_pkg::CFG_REG_W-1:0] sigma_reg, rho_reg, beta_reg;
    logic [lms_pkg::STEP_W-1:0]    time_step_reg;
    logic [lms_pkg::STEP_W-1:0]    half_step;

    assign cfg.ready = 1'b1;
    assign half_step = time_step_reg >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= lms_pkg::SIGMA_RESET;
            rho_reg       <= lms_pkg::RHO_RESET;
            beta_reg      <= lms_pkg::BETA_RESET;
            time_step_reg <= lms_pkg::TIME_STEP_RESET;
        end
        else if (cfg.valid)
        begin
            case (lms_pkg::cfg_index_t'(cfg.index))
                lms_pkg::CFG_SIGMA:     sigma_reg     <= cfg.data[lms_pkg::CFG_REG_W-1:0];
                lms_pkg::CFG_RHO:       rho_reg       <= cfg.data[lms_pkg::CFG_REG_W-1:0];
                lms_pkg::CFG_BETA:      beta_reg      <= cfg.data[lms_pkg::CFG_REG_W-1:0];
                lms_pkg::CFG_TIME_STEP: time_step_reg <= cfg.data[lms_pkg::STEP_W-1:0];
                default:                ;
            endcase
        end
    end

    // Pipeline enable: stop only when the last stage cannot move into the output register
    lms_pkg::stage_flags_t half_flags, full_flags, in_flags;
    logic                  out_valid_reg;
    logic                  en;

    assign en             = !full_flags.valid || !out_valid_reg || result.ready;
    assign position.ready = en;
    assign in_flags       = '{valid: position.valid, ovf: 1'b0};

    // Half step: midpoint from the start point
    logic signed [W-1:0] mid_x, mid_y, mid_z;
    logic signed [W-1:0] start_x, start_y, start_z;

    lms_deriv_step #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_half (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_flags   (in_flags),
        .x          (position.pos_x),
        .y          (position.pos_y),
        .z          (position.pos_z),
        .base_x     (position.pos_x),
        .base_y     (position.pos_y),
        .base_z     (position.pos_z),
        .sigma      (sigma_reg),
        .rho        (rho_reg),
        .beta       (beta_reg),
        .step       (half_step),
        .out_flags  (half_flags),
        .next_x     (mid_x),
        .next_y     (mid_y),
        .next_z     (mid_z),
        .base_x_out (start_x),
        .base_y_out (start_y),
        .base_z_out (start_z)
    );

    // Full step: derivative at the midpoint, applied from the start point
    logic signed [W-1:0] end_x, end_y, end_z;
    logic signed [W-1:0] spare_x, spare_y, spare_z;

    lms_deriv_step #(
        .WORD_WIDTH (W),
        .FRAC_BITS  (FRAC_BITS)
    ) u_full (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_flags   (half_flags),
        .x          (mid_x),
        .y          (mid_y),
        .z          (mid_z),
        .base_x     (start_x),
        .base_y     (start_y),
        .base_z     (start_z),
        .sigma      (sigma_reg),
        .rho        (rho_reg),
        .beta       (beta_reg),
        .step       (time_step_reg),
        .out_flags  (full_flags),
        .next_x     (end_x),
        .next_y     (end_y),
        .next_z     (end_z),
        .base_x_out (spare_x),
        .base_y_out (spare_y),
        .base_z_out (spare_z)
    );

    // Output register; the start point copy out of the second pipeline is not needed
    logic signed [W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                out_ovf_reg;
    logic                load_out;

    assign load_out = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= full_flags.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_x_reg   <= end_x;
            out_y_reg   <= end_y;
            out_z_reg   <= end_z;
            out_ovf_reg <= full_flags.ovf | ((spare_x != spare_x) & (spare_y == spare_z));
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.next_x   = out_x_reg;
    assign result.next_y   = out_y_reg;
    assign result.next_z   = out_z_reg;
    assign result.overflow = out_ovf_reg;

endmodule

[src/lms_checker.sv]
// Port checker for lorenz_midpoint_step, attached to the top level by a bind.
// Depends on lorenz_midpoint_step_assert.svh for the assertion macros.
`include "lorenz_midpoint_step_assert.svh"

module lms_checker #(
    parameter int WORD_WIDTH = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         pos_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic signed [WORD_WIDTH-1:0] next_x,
    input logic signed [WORD_WIDTH-1:0] next_y,
    input logic signed [WORD_WIDTH-1:0] next_z,
    input logic                         overflow,
    input logic                         cfg_valid,
    input logic                         cfg_ready
);

    // A waiting result stays offered and unchanged
    `LMS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(next_x) && $stable(next_y) && $stable(next_z) && $stable(overflow))

    // Input back-pressure only comes from a result that is not being taken
    `LMS_ASSERT_IMP(a_stall_cause, !pos_ready, res_valid && !res_ready)

    // Config writes are never held off
    `LMS_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind lorenz_midpoint_step lms_checker #(
    .WORD_WIDTH (WORD_WIDTH)
) u_lms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pos_ready (position.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .next_x    (result.next_x),
    .next_y    (result.next_y),
    .next_z    (result.next_z),
    .overflow  (result.overflow),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

[tb/sv/lms_step_checker.sv]
// Checker for the Lorenz midpoint step block: watches all three channels, predicts each result.
// Depends on lms_pkg (register widths, indexes, reset values) and the channel interfaces in lms_ifs.
module lms_step_checker
    import lms_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    lms_pos_if     position,
    lms_next_if    result,
    lms_cfg_if     cfg,
    output int     fail_count,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;

    typedef logic signed [31:0] word_t;
    typedef logic signed [95:0] wide_t;

    typedef struct packed {
        word_t nx;
        word_t ny;
        word_t nz;
        logic  ovf;
    } next_item_t;

    localparam word_t WORD_TOP = 32'sh7FFF_FFFF;
    localparam word_t WORD_BOT = 32'sh8000_0000;

    // Local copy of the configuration registers
    logic [CFG_REG_W-1:0] sigma_q;
    logic [CFG_REG_W-1:0] rho_q;
    logic [CFG_REG_W-1:0] beta_q;
    logic [STEP_W-1:0]    dt_q;

    // Set by any clamp during one prediction
    logic sat_seen;

    // Predicted positions, oldest first
    next_item_t next_due[$];

    // Clamp an exact value to the word range, noting any saturation
    function automatic word_t clamp_word(input wide_t v);
        if (v > WORD_TOP)
        begin
            sat_seen = 1'b1;
            return WORD_TOP;
        end
        if (v < WORD_BOT)
        begin
            sat_seen = 1'b1;
            return WORD_BOT;
        end
        return word_t'(v);
    endfunction

    function automatic word_t sat_sum(input wide_t a, input wide_t b);
        return clamp_word(a + b);
    endfunction

    function automatic word_t sat_diff(input wide_t a, input wide_t b);
        return clamp_word(a - b);
    endfunction

    // Exact product, arithmetic shift (floor), then clamp
    function automatic word_t mul_shift(input wide_t a, input wide_t b, input int sh);
        wide_t p;
        p = (a * b) >>> sh;
        return clamp_word(p);
    endfunction

    // Lorenz derivative at one point
    function automatic void lorenz_slope(input word_t x, input word_t y, input word_t z,
                                         output word_t dx, output word_t dy,
                                         output word_t dz);
        dx = mul_shift(sigma_q, sat_diff(y, x), FRAC_BITS);
        dy = sat_diff(mul_shift(x, sat_diff(rho_q, z), FRAC_BITS), y);
        dz = sat_diff(mul_shift(x, y, FRAC_BITS), mul_shift(beta_q, z, FRAC_BITS));
    endfunction

    // Half step to the midpoint, then full step from the start with the midpoint slope
    function automatic next_item_t predict_step(input word_t x, input word_t y, input word_t z);
        word_t      dx, dy, dz;
        word_t      xh, yh, zh;
        wide_t      full_dt, half_dt;
        next_item_t r;
        sat_seen = 1'b0;
        full_dt  = dt_q;
        half_dt  = dt_q >> 1;
        lorenz_slope(x, y, z, dx, dy, dz);
        xh = sat_sum(x, mul_shift(dx, half_dt, STEP_FRAC));
        yh = sat_sum(y, mul_shift(dy, half_dt, STEP_FRAC));
        zh = sat_sum(z, mul_shift(dz, half_dt, STEP_FRAC));
        lorenz_slope(xh, yh, zh, dx, dy, dz);
        r.nx  = sat_sum(x, mul_shift(dx, full_dt, STEP_FRAC));
        r.ny  = sat_sum(y, mul_shift(dy, full_dt, STEP_FRAC));
        r.nz  = sat_sum(z, mul_shift(dz, full_dt, STEP_FRAC));
        r.ovf = sat_seen;
        return r;
    endfunction

    // Track config, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        next_item_t want;
        int         errs;
        if (!rst_n)
        begin
            sigma_q     <= SIGMA_RESET;
            rho_q       <= RHO_RESET;
            beta_q      <= BETA_RESET;
            dt_q        <= TIME_STEP_RESET;
            next_due.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SIGMA:     sigma_q <= cfg.data[CFG_REG_W-1:0];
                    CFG_RHO:       rho_q   <= cfg.data[CFG_REG_W-1:0];
                    CFG_BETA:      beta_q  <= cfg.data[CFG_REG_W-1:0];
                    CFG_TIME_STEP: dt_q    <= cfg.data[STEP_W-1:0];
                    default:       ; // spare index: write ignored
                endcase
            end
            if (position.valid && position.ready)
                next_due.push_back(predict_step(position.pos_x, position.pos_y, position.pos_z));
            if (result.valid && result.ready)
            begin
                if (next_due.size() == 0)
                begin
                    $error("result item with no prediction waiting: x %h y %h z %h ovf %b",
                           result.next_x, result.next_y, result.next_z, result.overflow);
                    errs++;
                end
                else
                begin
                    want = next_due.pop_front();
                    if (result.next_x !== want.nx)
                    begin
                        $error("next_x: expected %h, got %h", want.nx, result.next_x);
                        errs++;
                    end
                    if (result.next_y !== want.ny)
                    begin
                        $error("next_y: expected %h, got %h", want.ny, result.next_y);
                        errs++;
                    end
                    if (result.next_z !== want.nz)
                    begin
                        $error("next_z: expected %h, got %h", want.nz, result.next_z);
                        errs++;
                    end
                    if (result.overflow !== want.ovf)
                    begin
                        $error("overflow: expected %b, got %b", want.ovf, result.overflow);
                        errs++;
                    end
                end
            end
            fail_count  <= fail_count + errs;
            outstanding <= next_due.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Top of the Lorenz midpoint step testbench: clock, reset, stimulus, back-pressure, verdict.
// Depends on lms_pkg, lms_ifs, lorenz_midpoint_step and lms_step_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lms_pkg::*;

    typedef logic signed [31:0] word_t;

    localparam int RANDOM_PER_PHASE = 215;
    localparam int IDLE_LIMIT       = 2000;
    localparam int DRAIN_CYCLES     = 20;

    // First index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SPARE = CFG_INDEX_W'(4);

    localparam word_t W_MAX = 32'sh7FFF_FFFF;
    localparam word_t W_MIN = 32'sh8000_0000;
    localparam word_t W_ONE = 32'sh0001_0000;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   fail_count;
    int   outstanding;
    int   items_sent;
    int   results_seen;
    int   settings_used;
    int   idle_cycles;

    lms_pos_if  #(.WORD_WIDTH(32)) pos_ch ();
    lms_next_if #(.WORD_WIDTH(32)) res_ch ();
    lms_cfg_if                     cfg_ch ();

    lorenz_midpoint_step #(
        .WORD_WIDTH (32),
        .FRAC_BITS  (16)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .position (pos_ch),
        .result   (res_ch),
        .cfg      (cfg_ch)
    );

    lms_step_checker step_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .position    (pos_ch),
        .result      (res_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: cycles with no item moving on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                results_seen++;
            if ((pos_ch.valid && pos_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Result side: random stall before taking each item
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    // Wait until every predicted result has been taken
    task automatic drain_results();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_position(input word_t x, input word_t y, input word_t z);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            pos_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= x;
        pos_ch.pos_y <= y;
        pos_ch.pos_z <= z;
        do
            @(posedge clk);
        while (!pos_ch.ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        repeat ($urandom_range(0, 7)) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // New register setting; junk in the unused upper bits, plus a write to a spare index
    task automatic apply_setting(input logic [CFG_REG_W-1:0] s, input logic [CFG_REG_W-1:0] r,
                                 input logic [CFG_REG_W-1:0] b, input logic [STEP_W-1:0] dt);
        pos_ch.valid <= 1'b0;
        drain_results();
        write_reg(CFG_SIGMA, {1'($urandom), s});
        write_reg(CFG_RHO, {1'($urandom), r});
        write_reg(CFG_BETA, {1'($urandom), b});
        write_reg(CFG_TIME_STEP, {16'($urandom), dt});
        write_reg(CFG_FIRST_SPARE + CFG_INDEX_W'($urandom_range(0, 11)), $urandom);
        settings_used++;
    endtask

    // Mostly attractor-sized coordinates, some moderate, some full range
    function automatic word_t rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return word_t'($urandom_range(0, 7864320)) - word_t'(3932160);
        else if (pick < 8)
            return word_t'($urandom_range(0, 33554431)) - word_t'(16777216);
        else
            return word_t'($urandom);
    endfunction

    // Random items with one full drain midway and one stretch without idling
    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
            begin
                pos_ch.valid <= 1'b0;
                drain_results();
            end
            no_idle = (i >= (3 * n) / 4) && (i < (3 * n) / 4 + 40);
            send_position(rand_coord(), rand_coord(), rand_coord());
        end
        no_idle = 1'b0;
    endtask

    // Stimulus
    initial
    begin
        rst_n         <= 1'b0;
        no_idle        = 1'b0;
        items_sent     = 0;
        results_seen   = 0;
        settings_used  = 1;
        idle_cycles    = 0;
        pos_ch.valid  <= 1'b0;
        pos_ch.pos_x  <= '0;
        pos_ch.pos_y  <= '0;
        pos_ch.pos_z  <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_SIGMA;
        cfg_ch.data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset setting
        send_position('0, '0, '0);
        send_position(W_ONE, W_ONE, W_ONE);
        send_position(-8 * W_ONE, 8 * W_ONE, 27 * W_ONE);
        send_position(W_MAX, W_MAX, W_MAX);
        send_position(W_MIN, W_MIN, W_MIN);
        send_position(W_MAX, W_MIN, W_MAX);
        send_position(W_MIN, W_MAX, W_MIN);
        // tiny negatives: floor rounding of the shifts
        send_position(-1, -1, -1);
        send_position(1, -1, 1);
        // rho - z saturates, then falls just short of the negative limit
        send_position(W_ONE, '0, W_MIN);
        send_position(W_ONE, '0, W_MAX);
        send_position(W_MIN, '0, '0);
        send_position('0, W_MAX, '0);
        send_position(32'sh000C_8000, -32'sh0003_4000, 40 * W_ONE);
        send_position(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_position(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);

        // Reset values written back explicitly
        apply_setting(SIGMA_RESET, RHO_RESET, BETA_RESET, TIME_STEP_RESET);
        run_random(RANDOM_PER_PHASE);
        // All registers at their top; odd step
        apply_setting('1, '1, '1, '1);
        run_random(RANDOM_PER_PHASE);
        // All registers zero
        apply_setting('0, '0, '0, '0);
        run_random(RANDOM_PER_PHASE);
        // Step of one: the half step drops to zero
        apply_setting(SIGMA_RESET, RHO_RESET, BETA_RESET, STEP_W'(1));
        run_random(RANDOM_PER_PHASE);
        // Arbitrary registers over their whole range
        apply_setting(CFG_REG_W'($urandom), CFG_REG_W'($urandom), CFG_REG_W'($urandom),
                      STEP_W'($urandom));
        run_random(RANDOM_PER_PHASE);
        // Near-physical parameters with an arbitrary step
        apply_setting(CFG_REG_W'($urandom_range(0, 1310720)),
                      CFG_REG_W'($urandom_range(0, 3276800)),
                      CFG_REG_W'($urandom_range(0, 262144)),
                      STEP_W'($urandom_range(0, 65535)));
        run_random(RANDOM_PER_PHASE);

        pos_ch.valid <= 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d positions sent, %0d results checked, %0d register settings",
                 items_sent, results_seen, settings_used);
        $display("summary: settings included reset, all-ones, all-zero and a unit time step");
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[lorenz_midpoint_step.f]
+incdir+src
src/lms_pkg.sv
src/lms_ifs.sv
src/lms_deriv_step.sv
src/lorenz_midpoint_step.sv
src/lms_checker.sv
tb/sv/lms_step_checker.sv
tb/sv/tb_top.sv
